/* sv/u2a_pkg.sv */
// ----------------------------------------------------------------------------
// u2a_pkg: shared types and constants for the unsigned-to-ASCII converter
// Widths, ASCII offsets, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package u2a_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RADIX_W         = 5;
  localparam int DIGIT_W         = 4;
  localparam int CHAR_W          = 7;
  localparam int OUT_DATA_W      = 8;
  localparam int BITS_PER_CYCLE  = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0] UPPER_OFFSET = 7'd55;
  localparam logic [CHAR_W-1:0] LOWER_OFFSET = 7'd87;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic rd;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic chunk_last;
    logic quot_zero;
    logic last_digit;
  } sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d <= 4'd9) begin
      return dx + ASCII_ZERO;
    end
    return dx + (upper ? UPPER_OFFSET : LOWER_OFFSET);
  endfunction

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end
    if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

endpackage

/* sv/u2a_ctrl.sv */
// ----------------------------------------------------------------------------
// u2a_ctrl: sequencer for the unsigned-to-ASCII converter
// Accepts one request, runs the digit divisions, then pops digits out.
// ----------------------------------------------------------------------------
module u2a_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  u2a_pkg::sts_t sts,
  output u2a_pkg::cmd_t cmd
);

  u2a_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= u2a_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      u2a_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = u2a_pkg::S_DIV;
        end
      end
      u2a_pkg::S_DIV: begin
        cmd.step = 1'b1;
        if (sts.chunk_last && sts.quot_zero) begin
          state_next = u2a_pkg::S_READ;
        end
      end
      u2a_pkg::S_READ: begin
        cmd.rd     = 1'b1;
        state_next = u2a_pkg::S_EMIT;
      end
      u2a_pkg::S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.pop    = 1'b1;
          state_next = sts.last_digit ? u2a_pkg::S_IDLE : u2a_pkg::S_READ;
        end
      end
      default: state_next = u2a_pkg::S_IDLE;
    endcase
  end

endmodule

/* sv/u2a_dpath.sv */
// ----------------------------------------------------------------------------
// u2a_dpath: divider, digit stack and character encoder
// Long division by the radix, several quotient bits per cycle; remainders
// are pushed on a small stack and read back most significant first.
// ----------------------------------------------------------------------------
module u2a_dpath #(
  parameter int VALUE_WIDTH = u2a_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  u2a_pkg::cmd_t                   cmd,
  output u2a_pkg::sts_t                   sts,
  input  logic [VALUE_WIDTH-1:0]          value,
  input  logic [u2a_pkg::RADIX_W-1:0]     radix,
  input  logic                            upper_case,
  output logic [u2a_pkg::CHAR_W-1:0]      character
);

  localparam int BPC    = u2a_pkg::BITS_PER_CYCLE;
  localparam int CHUNKS = (VALUE_WIDTH + BPC - 1) / BPC;
  localparam int PAD_W  = CHUNKS * BPC;
  localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int PTR_W  = $clog2(VALUE_WIDTH + 1);
  localparam int AW     = $clog2(VALUE_WIDTH);
  localparam int DW     = u2a_pkg::DIGIT_W;
  localparam int RW     = u2a_pkg::RADIX_W;

  logic [PAD_W-1:0] num;
  logic [PAD_W-1:0] num_next;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    rem_next;
  logic [RW-1:0]    base;
  logic             upper;
  logic [CNT_W-1:0] cnt;
  logic [PTR_W-1:0] ptr;
  logic [DW-1:0]    mem_q;
  logic [AW-1:0]    rd_addr;
  logic             chunk_last;

  logic [DW-1:0] digits_mem [VALUE_WIDTH];

  // one chunk of restoring division, MSB first
  always_comb begin
    logic [RW-1:0] t;
    logic [DW-1:0] r;
    logic [PAD_W-1:0] q;
    r = rem;
    q = num;
    for (int i = 0; i < BPC; i++) begin
      t = {r, q[PAD_W-1]};
      q = {q[PAD_W-2:0], 1'b0};
      if (t >= base) begin
        r    = DW'(t - base);
        q[0] = 1'b1;
      end else begin
        r = t[DW-1:0];
      end
    end
    rem_next = r;
    num_next = q;
  end

  assign chunk_last = (cnt == CNT_W'(CHUNKS - 1));
  assign rd_addr    = AW'(ptr - PTR_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ptr <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
      ptr <= '0;
    end else if (cmd.step) begin
      if (chunk_last) begin
        cnt <= '0;
        ptr <= ptr + PTR_W'(1);
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end else if (cmd.pop) begin
      ptr <= ptr - PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num   <= PAD_W'(value);
      rem   <= '0;
      base  <= u2a_pkg::clamp_radix(radix);
      upper <= upper_case;
    end else if (cmd.step) begin
      num <= num_next;
      rem <= chunk_last ? '0 : rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && chunk_last) begin
      digits_mem[ptr[AW-1:0]] <= rem_next;
    end
    if (cmd.rd) begin
      mem_q <= digits_mem[rd_addr];
    end
  end

  assign character      = u2a_pkg::digit_char(mem_q, upper);
  assign sts.chunk_last = chunk_last;
  assign sts.quot_zero  = (num_next == '0);
  assign sts.last_digit = (ptr == PTR_W'(1));

endmodule

/* sv/unsigned_to_ascii_radix_top.sv */
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix_top: unsigned number to ASCII digits, radix 2..16
// Emits the digits most significant first, one per output request, with
// tlast on the final digit.
//
//   channel  dir  tdata (low bit up)                        tlast
//   s_axis   in   value, radix[4:0], upper_case, zero pad   -
//   m_axis   out  character[6:0], zero                      last digit
//
// The divider retires 8 quotient bits a cycle; each digit is then read back
// from the stack and held on the output until m_tready is high.
// One request in flight; s_tready is high only while idle.
// rst is synchronous; the digit stack needs no clearing.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_radix_top #(
  parameter int VALUE_WIDTH = u2a_pkg::VALUE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // value, radix[4:0], upper_case, zero pad
  input  logic [((VALUE_WIDTH + u2a_pkg::RADIX_W + 1 + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // character[6:0], zero
  output logic [u2a_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic m_tlast
);

  localparam int RW = u2a_pkg::RADIX_W;

  u2a_pkg::cmd_t               cmd;
  u2a_pkg::sts_t               sts;
  logic [u2a_pkg::CHAR_W-1:0]  character;

  u2a_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  u2a_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .value      (s_tdata[VALUE_WIDTH-1:0]),
    .radix      (s_tdata[VALUE_WIDTH +: RW]),
    .upper_case (s_tdata[VALUE_WIDTH + RW]),
    .character  (character)
  );

  assign m_tdata = u2a_pkg::OUT_DATA_W'(character);
  assign m_tlast = sts.last_digit;

  a_one_side : assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output active together");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request taken while busy");

  a_idle_after_last : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not idle after last digit");

  a_char_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:0] >= 7'd48 && m_tdata[6:0] <= 7'd102))
    else $error("character out of range");

endmodule
